FILE: src/wtcc_pkg.sv
// Package for the witness trace consistency checker.
// Holds payload and command types, event and verdict codes, and parameter defaults.
// No dependencies.
package wtcc_pkg;

   localparam int THREADS_DEFAULT       = 16;
   localparam int TARGETS_DEFAULT       = 256;
   localparam int VALUE_BITS_DEFAULT    = 32;
   localparam int POSITION_BITS_DEFAULT = 16;

   localparam logic [2:0] OP_READ    = 3'd0;
   localparam logic [2:0] OP_WRITE   = 3'd1;
   localparam logic [2:0] OP_ACQUIRE = 3'd2;
   localparam logic [2:0] OP_RELEASE = 3'd3;

   localparam logic [2:0] V_OK            = 3'd0;
   localparam logic [2:0] V_ORDER         = 3'd1;
   localparam logic [2:0] V_LOCK_HELD     = 3'd2;
   localparam logic [2:0] V_BAD_RELEASE   = 3'd3;
   localparam logic [2:0] V_READ_MISMATCH = 3'd4;
   localparam logic [2:0] V_SKIPPED       = 3'd5;

   typedef struct packed {
      logic        first_of_witness;
      logic [2:0]  opcode;
      logic [3:0]  thread_id;
      logic [15:0] position_in_thread;
      logic [7:0]  target_id;
      logic [31:0] target_value;
   } req_type;

   typedef struct packed {
      logic [2:0] verdict;
      logic       witness_failed;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

endpackage

FILE: src/wtcc_ctrl.sv
// Controller of the witness trace consistency checker.
// Sequences capture and commit of one event; depends on wtcc_pkg.
module wtcc_ctrl import wtcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_CHECK = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.commit  = (state_ff == ST_CHECK) && !sts.out_busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_then_check: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_CHECK))
      else $error("Captured event did not move to the check state.");

endmodule

FILE: src/wtcc_datapath.sv
// Datapath of the witness trace consistency checker.
// Holds thread, lock and variable tables, the failure latch and the result register;
// depends on wtcc_pkg.
module wtcc_datapath import wtcc_pkg::*; #(
   parameter int THREADS       = THREADS_DEFAULT,
   parameter int TARGETS       = TARGETS_DEFAULT,
   parameter int VALUE_BITS    = VALUE_BITS_DEFAULT,
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_payload,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int THR_W     = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int TGT_DEPTH = (TARGETS < 256) ? TARGETS : 256;
   localparam int TGT_W     = (TGT_DEPTH > 1) ? $clog2(TGT_DEPTH) : 1;

   logic [THR_W-1:0]         thr_idx;
   logic [TGT_W-1:0]         tgt_idx;
   logic [THR_W-1:0]         thr_ff;
   logic [TGT_W-1:0]         tgt_ff;
   logic [2:0]               op_ff;
   logic [POSITION_BITS-1:0] pos_ff;
   logic [VALUE_BITS-1:0]    val_ff;

   logic [POSITION_BITS-1:0] next_pos_ff [THREADS];
   logic [TGT_DEPTH-1:0]     held_ff;
   logic [TGT_DEPTH-1:0]     known_ff;
   logic                     fail_ff;

   logic [THR_W-1:0]         owner_mem [TGT_DEPTH];
   logic [VALUE_BITS-1:0]    value_mem [TGT_DEPTH];
   logic [THR_W-1:0]         owner_rd_ff;
   logic [VALUE_BITS-1:0]    value_rd_ff;

   logic                     rsp_valid_ff;
   rsp_type                  rsp_payload_ff;

   logic [POSITION_BITS-1:0] cur_pos;
   logic                     held;
   logic                     known;
   logic [2:0]               verdict;

   always_comb begin
      thr_idx = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_payload.thread_id == 4'(i)) begin
            thr_idx = THR_W'(i % THREADS);
         end
      end
   end

   always_comb begin
      tgt_idx = '0;
      for (int i = 0; i < 256; i++) begin
         if (req_payload.target_id == 8'(i)) begin
            tgt_idx = TGT_W'(i % TGT_DEPTH);
         end
      end
   end

   assign cur_pos = next_pos_ff[thr_ff];
   assign held    = held_ff[tgt_ff];
   assign known   = known_ff[tgt_ff];

   always_comb begin
      if (cur_pos != pos_ff) begin
         verdict = V_ORDER;
      end else if ((op_ff == OP_ACQUIRE) && held) begin
         verdict = V_LOCK_HELD;
      end else if ((op_ff == OP_RELEASE) && !(held && (owner_rd_ff == thr_ff))) begin
         verdict = V_BAD_RELEASE;
      end else if ((op_ff == OP_READ) && known && (value_rd_ff != val_ff)) begin
         verdict = V_READ_MISMATCH;
      end else begin
         verdict = V_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         thr_ff      <= thr_idx;
         tgt_ff      <= tgt_idx;
         op_ff       <= req_payload.opcode;
         pos_ff      <= POSITION_BITS'(req_payload.position_in_thread);
         val_ff      <= VALUE_BITS'(req_payload.target_value);
         owner_rd_ff <= owner_mem[tgt_idx];
         value_rd_ff <= value_mem[tgt_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !fail_ff && (verdict == V_OK)) begin
         if (op_ff == OP_ACQUIRE) begin
            owner_mem[tgt_ff] <= thr_ff;
         end
         if ((op_ff == OP_READ) || (op_ff == OP_WRITE)) begin
            value_mem[tgt_ff] <= val_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.capture && req_payload.first_of_witness)) begin
         for (int i = 0; i < THREADS; i++) begin
            next_pos_ff[i] <= '0;
         end
         held_ff  <= '0;
         known_ff <= '0;
         fail_ff  <= 1'b0;
      end else if (cmd.commit && !fail_ff) begin
         if (verdict != V_OK) begin
            fail_ff <= 1'b1;
         end else begin
            next_pos_ff[thr_ff] <= cur_pos + 1'b1;
            if (op_ff == OP_ACQUIRE) begin
               held_ff[tgt_ff] <= 1'b1;
            end else if (op_ff == OP_RELEASE) begin
               held_ff[tgt_ff] <= 1'b0;
            end else if ((op_ff == OP_READ) || (op_ff == OP_WRITE)) begin
               known_ff[tgt_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (fail_ff) begin
            rsp_payload_ff.verdict        <= V_SKIPPED;
            rsp_payload_ff.witness_failed <= 1'b1;
         end else begin
            rsp_payload_ff.verdict        <= verdict;
            rsp_payload_ff.witness_failed <= (verdict != V_OK);
         end
      end
   end

   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_payload_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("Result register overwritten before its transfer.");

   a_skip_after_fail: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && fail_ff) |=>
         (rsp_payload_ff.verdict == V_SKIPPED) && rsp_payload_ff.witness_failed)
      else $error("Event after a failure was not reported as skipped.");

   a_fail_latches: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !fail_ff && (verdict != V_OK)) |=> fail_ff)
      else $error("Failing event did not set the failure latch.");

endmodule

FILE: src/witness_trace_consistency_check_unit.sv
// Channel   Direction  Ports                                  Payload
// request   in         req_valid, req_ready, req_payload      req_type
// response  out        rsp_valid, rsp_ready, rsp_payload      rsp_type
//
// Each event is accepted in the idle state, which reads the lock-owner and
// variable-value memories; the check state then checks it and updates the tables.
// Reset clears the thread counters, the lock and variable valid bits and the failure latch.
// A result waits in its output register while the next event is accepted; the check
// cycle waits until that register is free.
// Top level of the witness trace consistency checker; depends on wtcc_pkg,
// wtcc_ctrl and wtcc_datapath.
module witness_trace_consistency_check_unit import wtcc_pkg::*; #(
   parameter int THREADS       = THREADS_DEFAULT,
   parameter int TARGETS       = TARGETS_DEFAULT,
   parameter int VALUE_BITS    = VALUE_BITS_DEFAULT,
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type cmd;
   sts_type sts;

   wtcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wtcc_datapath #(
      .THREADS       (THREADS),
      .TARGETS       (TARGETS),
      .VALUE_BITS    (VALUE_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
